/* design/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/jsbe_pkg.sv */
`timescale 1ns / 1ps

package jsbe_pkg;

   // Longest escaped run for one transaction: two quotes and a six-byte escape.
   localparam int MAX_RESULTS = 8;
   localparam int LEN_W       = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W       = $clog2(MAX_RESULTS);
   localparam int ESC_LEN_W   = 3;

   // Default depth of the queue between the classifier and the emitter.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Characters used by the escaper.
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BSLASH    = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_HEX_ALPHA = 8'h57;
   localparam logic [7:0] CH_NONE      = 8'h00;

   // Control codes with a short escape, and their letters.
   localparam logic [7:0] CC_BACKSPACE = 8'h08;
   localparam logic [7:0] CC_TAB       = 8'h09;
   localparam logic [7:0] CC_NEWLINE   = 8'h0A;
   localparam logic [7:0] CC_FORMFEED  = 8'h0C;
   localparam logic [7:0] CC_RETURN    = 8'h0D;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_R         = 8'h72;

   // One classified transaction: the bytes to send and how many there are.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] seq_bytes;
      logic [LEN_W-1:0]            seq_len;
   } seq_entry_type;

   // Queue status seen by the classifier and the emitter.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Lower-case hex digit of a nibble.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CH_ZERO + {4'b0, nib};
      end
      return CH_HEX_ALPHA + {4'b0, nib};
   endfunction

   // Letter of the short escape for a control code, CH_NONE if it has none.
   function automatic logic [7:0] short_escape(input logic [7:0] c);
      logic [7:0] letter;
      letter = CH_NONE;
      unique case (c)
         CC_BACKSPACE: letter = CH_B;
         CC_TAB:       letter = CH_T;
         CC_NEWLINE:   letter = CH_N;
         CC_FORMFEED:  letter = CH_F;
         CC_RETURN:    letter = CH_R;
         default:      letter = CH_NONE;
      endcase
      return letter;
   endfunction

endpackage

/* design/jsbe_if.sv */
`timescale 1ns / 1ps

// Request channel: one string byte with its framing marks.
interface jsbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       string_start;
   logic       string_end;
   logic       no_byte;

   modport source(output valid, output data_byte, output string_start,
                  output string_end, output no_byte, input ready);
   modport sink(input valid, input data_byte, input string_start,
                input string_end, input no_byte, output ready);
endinterface

// Response channel: one escaped output byte.
interface jsbe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source(output valid, output out_byte, output last_of_run, input ready);
   modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

/* design/jsbe_front.sv */
`timescale 1ns / 1ps

module jsbe_front (
   jsbe_req_if.sink                  req_ch,
   input  jsbe_pkg::queue_status_type q_status,
   output logic                      push,
   output jsbe_pkg::seq_entry_type   push_entry
);
   import jsbe_pkg::*;

   logic [7:0]           esc [MAX_RESULTS];
   logic [ESC_LEN_W-1:0] esc_len;
   logic [ESC_LEN_W-1:0] mid_len;
   logic [7:0]           letter;
   logic [LEN_W-1:0]     pos;
   logic [LEN_W-1:0]     rel;
   logic [LEN_W-1:0]     off;

   // Escape sequence of the data byte alone.
   always_comb begin
      letter = short_escape(req_ch.data_byte);
      for (int i = 0; i < MAX_RESULTS; i++) begin
         esc[i] = CH_ZERO;
      end
      if (req_ch.data_byte == CH_QUOTE || req_ch.data_byte == CH_BSLASH) begin
         esc[0]  = CH_BSLASH;
         esc[1]  = req_ch.data_byte;
         esc_len = ESC_LEN_W'(2);
      end else if (req_ch.data_byte >= CH_SPACE) begin
         esc[0]  = req_ch.data_byte;
         esc_len = ESC_LEN_W'(1);
      end else if (letter != CH_NONE) begin
         esc[0]  = CH_BSLASH;
         esc[1]  = letter;
         esc_len = ESC_LEN_W'(2);
      end else begin
         esc[0]  = CH_BSLASH;
         esc[1]  = CH_U;
         esc[2]  = CH_ZERO;
         esc[3]  = CH_ZERO;
         esc[4]  = hex_digit(req_ch.data_byte[7:4]);
         esc[5]  = hex_digit(req_ch.data_byte[3:0]);
         esc_len = ESC_LEN_W'(6);
      end
   end

   // Frame the escape with the opening and closing quotes.
   always_comb begin
      off     = {{(LEN_W-1){1'b0}}, req_ch.string_start};
      mid_len = req_ch.no_byte ? '0 : esc_len;
      pos     = '0;
      rel     = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         pos = LEN_W'(i);
         rel = pos - off;
         if (req_ch.string_start && i == 0) begin
            push_entry.seq_bytes[i] = CH_QUOTE;
         end else if (rel < {{(LEN_W-ESC_LEN_W){1'b0}}, mid_len}) begin
            push_entry.seq_bytes[i] = esc[rel[IDX_W-1:0]];
         end else begin
            push_entry.seq_bytes[i] = CH_QUOTE;
         end
      end
      push_entry.seq_len = off + {{(LEN_W-ESC_LEN_W){1'b0}}, mid_len}
                         + {{(LEN_W-1){1'b0}}, req_ch.string_end};
   end

   // Accept while the queue has room; empty transactions are dropped here.
   assign req_ch.ready = !q_status.full;
   assign push = req_ch.valid && !q_status.full && (push_entry.seq_len != '0);

endmodule

/* design/jsbe_queue.sv */
`timescale 1ns / 1ps

module jsbe_queue #(
   parameter int DEPTH = jsbe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  jsbe_pkg::seq_entry_type    push_entry,
   input  logic                       pop,
   output jsbe_pkg::seq_entry_type    head_entry,
   output jsbe_pkg::queue_status_type q_status
);
   import jsbe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   seq_entry_type    slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry     = slots_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);

endmodule

/* design/jsbe_back.sv */
`timescale 1ns / 1ps

module jsbe_back (
   input  logic                       clock,
   input  logic                       reset,
   input  jsbe_pkg::seq_entry_type    head_entry,
   input  jsbe_pkg::queue_status_type q_status,
   output logic                       pop,
   jsbe_rsp_if.source                 rsp_ch
);
   import jsbe_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             last_ff, last_in;
   logic             load;
   logic             at_last;

   // Load the output register from a non-empty queue whenever it is free or being drained.
   assign load    = !q_status.empty && (!rsp_valid_ff || rsp_ch.ready);
   assign at_last = ({1'b0, idx_ff} + 1'b1) == head_entry.seq_len;
   assign pop     = load && at_last;

   // Step through the bytes of the head entry.
   always_comb begin
      idx_in       = idx_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (load) begin
         out_byte_in  = head_entry.seq_bytes[idx_ff];
         last_in      = at_last;
         rsp_valid_in = 1'b1;
         idx_in       = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = out_byte_ff;
   assign rsp_ch.last_of_run = last_ff;

endmodule

/* design/json_string_byte_escaper_unit.sv */
`timescale 1ns / 1ps

// JSON string byte escaper.
// The request channel (req_ch) takes one string byte per transaction with
// marks for the first and last byte of a string; no_byte marks a transaction
// that carries no text. The response channel (rsp_ch) returns the escaped JSON
// text one byte per transaction, with last_of_run on the final byte that a
// request caused. A request that causes no bytes is absorbed silently.
// A classifier builds the full escaped run (one to eight bytes) in the cycle
// a request is accepted and writes it into a small queue; an emitter sends
// one byte of the head run per cycle, while the receiver takes bytes,
// through a registered output. The first byte of a run passes through the
// queue and then the output register before it is valid.
// Throughput: one output byte per cycle while the receiver takes bytes;
// plain bytes flow at one request per cycle, while escapes stall the
// request side once the queue fills.
// Reset empties the queue and clears the output valid flag; no clearing pass is needed.
// When the receiver stalls, the output byte holds, the queue fills and
// req_ch.ready drops until space frees up.
module json_string_byte_escaper_unit #(
   parameter int QUEUE_DEPTH = jsbe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   jsbe_req_if.sink    req_ch,
   jsbe_rsp_if.source  rsp_ch
);
   import jsbe_pkg::*;

   seq_entry_type    push_entry;
   seq_entry_type    head_entry;
   queue_status_type q_status;
   logic             push;
   logic             pop;

   // Classification of incoming transactions.
   jsbe_front u_front (
      .req_ch     (req_ch),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   jsbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // Byte emitter.
   jsbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

/* design/jsbe_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_string_start,
   input logic       req_string_end,
   input logic       req_no_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   logic [7:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_done;

   // Count requests whose run has not been fully delivered yet.
   assign req_fire = req_valid && req_ready
                  && (req_string_start || req_string_end || !req_no_byte);
   assign rsp_done = rsp_valid && rsp_ready && rsp_last_of_run;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_done) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_done && !req_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run), "stalled response changed")
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")
   `ASSERT_CLK(a_no_orphan_rsp, clock, reset, rsp_valid |-> pending_ff != 8'd0, "response without an outstanding request")
   `ASSERT_CLK(a_idle_ready, clock, reset, pending_ff == 8'd0 |-> req_ready, "idle block refuses a request")

endmodule

bind json_string_byte_escaper_unit jsbe_checker u_jsbe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_string_start (req_ch.string_start),
   .req_string_end   (req_ch.string_end),
   .req_no_byte      (req_ch.no_byte),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_out_byte     (rsp_ch.out_byte),
   .rsp_last_of_run  (rsp_ch.last_of_run)
);

/* verif/tb_json_string_byte_escaper_unit.sv */
`timescale 1ns / 1ps

module tb_json_string_byte_escaper_unit;
   import jsbe_pkg::*;

   localparam int  RANDOM_ITEMS = 300;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  DRAIN_CYCLES = 20;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   // Expected escaped output, kept in order and checked as responses arrive.
   class escape_scoreboard;
      typedef struct packed {
         logic [7:0] out_byte;
         logic       last_of_run;
      } escaped_byte_type;

      escaped_byte_type expected_bytes[$];
      int               error_count = 0;

      // Append one expected byte; last_of_run is fixed up by the caller.
      function void push_byte(input logic [7:0] b);
         escaped_byte_type entry;
         entry.out_byte    = b;
         entry.last_of_run = 1'b0;
         expected_bytes.push_back(entry);
      endfunction

      function logic [7:0] hex_char(input logic [3:0] nib);
         if (nib < 4'd10) begin
            return CH_ZERO + {4'b0, nib};
         end
         return CH_LOWER_A + {4'b0, nib} - 8'd10;
      endfunction

      // Predict the escaped run of one accepted request transaction.
      function void note_request(input logic [7:0] text_byte, input logic opens,
                                 input logic closes, input logic empty);
         int         run_start;
         logic [7:0] letter;
         run_start = expected_bytes.size();
         if (opens) begin
            push_byte(CH_QUOTE);
         end
         if (!empty) begin
            if (text_byte == CH_QUOTE || text_byte == CH_BSLASH) begin
               push_byte(CH_BSLASH);
               push_byte(text_byte);
            end else if (text_byte >= CH_SPACE) begin
               push_byte(text_byte);
            end else begin
               case (text_byte)
                  CC_BACKSPACE: letter = CH_B;
                  CC_TAB:       letter = CH_T;
                  CC_NEWLINE:   letter = CH_N;
                  CC_FORMFEED:  letter = CH_F;
                  CC_RETURN:    letter = CH_R;
                  default:      letter = CH_NONE;
               endcase
               push_byte(CH_BSLASH);
               if (letter != CH_NONE) begin
                  push_byte(letter);
               end else begin
                  push_byte(CH_U);
                  push_byte(CH_ZERO);
                  push_byte(CH_ZERO);
                  push_byte(hex_char(text_byte[7:4]));
                  push_byte(hex_char(text_byte[3:0]));
               end
            end
         end
         if (closes) begin
            push_byte(CH_QUOTE);
         end
         if (expected_bytes.size() > run_start) begin
            expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
         end
      endfunction

      // Compare one accepted response transaction with the oldest expectation.
      function void check_response(input logic [7:0] got_byte, input logic got_last);
         escaped_byte_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected response, out_byte %h last_of_run %b",
                     $time, got_byte, got_last);
            error_count++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, want.out_byte, got_byte);
            error_count++;
         end
         if (got_last !== want.last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %b, actual %b",
                     $time, want.last_of_run, got_last);
            error_count++;
         end
      endfunction

      function int outstanding();
         return expected_bytes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic steady_flow;
   int   cycle_count;

   jsbe_req_if req_ch();
   jsbe_rsp_if rsp_ch();

   escape_scoreboard escapes = new();

   json_string_byte_escaper_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Free-running clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_json_string_byte_escaper_unit: done, errors");
         $finish;
      end
   end

   // Check every accepted response transaction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         escapes.check_response(rsp_ch.out_byte, rsp_ch.last_of_run);
      end
   end

   // Receiver: stall a random number of cycles before taking each byte, unless steady_flow is set.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 3);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Send one request transaction after a random gap (none while steady_flow is set) and wait for acceptance.
   task automatic send_item(input logic [7:0] text_byte, input logic opens,
                            input logic closes, input logic empty);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= text_byte;
      req_ch.string_start <= opens;
      req_ch.string_end   <= closes;
      req_ch.no_byte      <= empty;
      do @(posedge clock); while (!req_ch.ready);
      escapes.note_request(text_byte, opens, closes, empty);
   endtask

   // Text bytes biased toward the ones that need escaping.
   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(0, 31));
         1:       return $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send a well-formed string; returns how many transactions produced output.
   task automatic send_string(output int produced);
      int   length;
      logic empty_slot;
      length   = $urandom_range(0, 8);
      produced = 0;
      if (length == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b1);
         produced = 1;
         return;
      end
      for (int i = 0; i < length; i++) begin
         // Now and then an empty transaction sits inside the string.
         empty_slot = ($urandom_range(0, 15) == 0);
         if (empty_slot && i != 0 && i != length - 1) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
         end else begin
            send_item(pick_text_byte(), i == 0, i == length - 1, 1'b0);
            produced++;
         end
      end
   endtask

   initial begin
      int   produced;
      int   random_count;
      logic opens;
      logic closes;
      logic empty;
      logic pressure_done;

      reset               = 1'b1;
      steady_flow         = 1'b0;
      cycle_count         = 0;
      req_ch.valid        = 1'b0;
      req_ch.data_byte    = 8'h00;
      req_ch.string_start = 1'b0;
      req_ch.string_end   = 1'b0;
      req_ch.no_byte      = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty strings, mark corners and every escape class.
      send_item(8'h00, 1'b1, 1'b1, 1'b1);
      send_item(8'hFF, 1'b0, 1'b0, 1'b1);
      send_item(8'h41, 1'b1, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0, 1'b0);
      send_item(CC_BACKSPACE, 1'b0, 1'b0, 1'b0);
      send_item(CC_TAB, 1'b0, 1'b0, 1'b0);
      send_item(CC_NEWLINE, 1'b0, 1'b0, 1'b0);
      send_item(CC_FORMFEED, 1'b0, 1'b0, 1'b0);
      send_item(CC_RETURN, 1'b0, 1'b0, 1'b0);
      send_item(8'h0B, 1'b0, 1'b0, 1'b0);
      send_item(8'h1F, 1'b0, 1'b0, 1'b0);
      send_item(CH_QUOTE, 1'b0, 1'b0, 1'b0);
      send_item(CH_BSLASH, 1'b0, 1'b0, 1'b0);
      send_item(CH_SPACE, 1'b0, 1'b0, 1'b0);
      send_item(8'h7F, 1'b0, 1'b0, 1'b0);
      send_item(8'h80, 1'b0, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1, 1'b0);
      // Marks out of order: end without start, start twice, lone marks.
      send_item(8'h5A, 1'b0, 1'b1, 1'b0);
      send_item(8'h61, 1'b1, 1'b0, 1'b0);
      send_item(8'h62, 1'b1, 1'b0, 1'b0);
      send_item(8'hAA, 1'b0, 1'b1, 1'b1);
      send_item(8'h55, 1'b1, 1'b0, 1'b1);
      // Framed on one transaction: two control bytes, which give the longest runs, and a quote.
      send_item(8'h01, 1'b1, 1'b1, 1'b0);
      send_item(CH_QUOTE, 1'b1, 1'b1, 1'b0);
      send_item(8'h1A, 1'b1, 1'b1, 1'b0);

      // Random part: mostly well-formed strings, some noise, in phases.
      random_count  = 0;
      pressure_done = 1'b0;
      while (random_count < RANDOM_ITEMS) begin
         steady_flow = (((random_count / 40) % 3) == 1);
         if (!pressure_done && random_count >= RANDOM_ITEMS / 2) begin
            // Drop valid, then hold off until every expected byte has come back.
            @(negedge clock);
            req_ch.valid <= 1'b0;
            while (escapes.outstanding() > 0) @(posedge clock);
            pressure_done = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            opens  = 1'($urandom_range(0, 1));
            closes = 1'($urandom_range(0, 1));
            empty  = 1'($urandom_range(0, 1));
            send_item(8'($urandom_range(0, 255)), opens, closes, empty);
            if (opens || closes || !empty) begin
               random_count++;
            end
         end else begin
            send_string(produced);
            random_count += produced;
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      steady_flow  = 1'b0;
      while (escapes.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (escapes.error_count == 0 && escapes.outstanding() == 0) begin
         $display("tb_json_string_byte_escaper_unit: done, clean");
      end else begin
         $display("tb_json_string_byte_escaper_unit: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/jsbe_pkg.sv
design/jsbe_if.sv
design/jsbe_front.sv
design/jsbe_queue.sv
design/jsbe_back.sv
design/json_string_byte_escaper_unit.sv
design/jsbe_checker.sv
verif/tb_json_string_byte_escaper_unit.sv
